[hdl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types, constants and decode functions for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

	// Byte classes.
	localparam logic [7:0] LEAD_BASE = 8'hC0;
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG  = 8'h80;

	// Code point constants.
	localparam logic [31:0] REPLACEMENT    = 32'h0000_FFFD;
	localparam logic [31:0] ASCII_LIMIT    = 32'h0000_0080;
	localparam logic [31:0] SURR_MASK      = 32'hFFFF_F800;
	localparam logic [31:0] SURR_BASE      = 32'h0000_D800;
	localparam logic [31:0] NONCHAR_MASK   = 32'hFFFF_FFFE;
	localparam logic [31:0] NONCHAR_BASE   = 32'h0000_FFFE;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// One result transaction.
	typedef struct packed {
		logic [31:0] code_point;
		logic        last;
	} result_t;

	// Results produced by one decoded item; slot b is used only with slot a.
	typedef struct packed {
		logic    a_valid;
		logic    b_valid;
		result_t a;
		result_t b;
	} push_t;

	// Initial accumulator value for a lead byte (0xC0 and above).
	function automatic logic [31:0] lead_value(input logic [7:0] b);
		logic [5:0] idx;
		logic [4:0] v;
		begin
			idx = b[5:0];
			if (!idx[5]) begin
				v = idx[4:0];
			end else if (!idx[4]) begin
				v = {1'b0, idx[3:0]};
			end else if (!idx[3]) begin
				v = {2'b00, idx[2:0]};
			end else if (!idx[2]) begin
				v = {3'b000, idx[1:0]};
			end else if (!idx[1]) begin
				v = {4'b0000, idx[0]};
			end else begin
				v = 5'd0;
			end
			lead_value = {27'd0, v};
		end
	endfunction

	// Replace out-of-place values when a sequence closes.
	function automatic logic [31:0] close_value(input logic [31:0] v);
		begin
			if ((v < ASCII_LIMIT) || ((v & SURR_MASK) == SURR_BASE) ||
					((v & NONCHAR_MASK) == NONCHAR_BASE)) begin
				close_value = REPLACEMENT;
			end else begin
				close_value = v;
			end
		end
	endfunction

endpackage

[hdl/u8d_decode.sv]
// ----------------------------------------------------------------------------
// u8d_decode
// Input register, sequence state and single-pass decode of one byte into
// zero, one or two results.
// ----------------------------------------------------------------------------
module u8d_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             data_valid,
	output logic             data_ready,
	input  logic [7:0]       data_byte,
	input  logic             flush,
	input  logic             space_ok,
	output u8d_pkg::push_t   push
);
	import u8d_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        flush_s1;
	logic        seq_open_q;
	logic [31:0] acc_q;
	logic        advance;
	logic        is_cont;
	logic        is_lead;
	logic        open_d;
	logic [31:0] acc_d;
	push_t       push_d;

	// The input register drains whenever the queue can take two results.
	assign advance    = valid_s1 && space_ok;
	assign data_ready = !valid_s1 || space_ok;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ready && data_valid) begin
			byte_s1  <= data_byte;
			flush_s1 <= flush;
		end
	end

	assign is_cont = (byte_s1 & CONT_MASK) == CONT_TAG;
	assign is_lead = byte_s1 >= LEAD_BASE;

	// Decode of the registered byte against the current sequence state.
	always_comb begin
		open_d = seq_open_q;
		acc_d  = acc_q;
		push_d = '0;
		if (flush_s1) begin
			push_d.a_valid      = seq_open_q;
			push_d.a.code_point = close_value(acc_q);
			push_d.a.last       = 1'b1;
			open_d              = 1'b0;
			acc_d               = '0;
		end else if (seq_open_q && is_cont) begin
			acc_d = {acc_q[25:0], 6'd0} + {26'd0, byte_s1[5:0]};
		end else begin
			// A pending sequence closes first.
			if (seq_open_q) begin
				push_d.a_valid      = 1'b1;
				push_d.a.code_point = close_value(acc_q);
				push_d.a.last       = is_lead;
			end
			if (is_lead) begin
				open_d = 1'b1;
				acc_d  = lead_value(byte_s1);
			end else begin
				open_d = 1'b0;
				acc_d  = '0;
				if (seq_open_q) begin
					push_d.b_valid      = 1'b1;
					push_d.b.code_point = {24'd0, byte_s1};
					push_d.b.last       = 1'b1;
				end else begin
					push_d.a_valid      = 1'b1;
					push_d.a.code_point = {24'd0, byte_s1};
					push_d.a.last       = 1'b1;
				end
			end
		end
	end

	// Sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_open_q <= 1'b0;
			acc_q      <= '0;
		end else if (advance) begin
			seq_open_q <= open_d;
			acc_q      <= acc_d;
		end
	end

	// Results are only pushed on the cycle the item leaves the register.
	always_comb begin
		push         = push_d;
		push.a_valid = push_d.a_valid && advance;
		push.b_valid = push_d.b_valid && advance;
	end

endmodule

[hdl/u8d_outq.sv]
// ----------------------------------------------------------------------------
// u8d_outq
// Small result queue that takes up to two results per cycle and gives one.
// ----------------------------------------------------------------------------
module u8d_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  u8d_pkg::push_t   push,
	output logic             space_ok,
	output logic             result_valid,
	input  logic             result_ready,
	output logic [31:0]      code_point,
	output logic             last
);
	import u8d_pkg::*;

	result_t        mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QCW-1:0] count_q;
	logic [QAW-1:0] wr_next;
	logic           pop;
	logic [QCW-1:0] n_push;

	assign wr_next  = wr_q + QAW'(1);
	assign pop      = result_valid && result_ready;
	assign n_push   = QCW'(push.a_valid) + QCW'(push.b_valid);
	assign space_ok = count_q <= QCW'(QDEPTH - 2);

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push.a_valid) begin
			mem_q[wr_q] <= push.a;
		end
		if (push.b_valid) begin
			mem_q[wr_next] <= push.b;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QAW'(n_push);
			rd_q    <= rd_q + QAW'(pop);
			count_q <= count_q + n_push - QCW'(pop);
		end
	end

	assign result_valid = count_q != '0;
	assign code_point   = mem_q[rd_q].code_point;
	assign last         = mem_q[rd_q].last;

endmodule

[hdl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a stream of UTF-8 bytes into 32-bit code points.
// ----------------------------------------------------------------------------
// Input channel: data_valid/data_ready with data_byte and flush. Each
// transaction carries one byte, or an end-of-text marker when flush is set.
// Output channel: result_valid/result_ready with code_point and last. An
// input transaction yields zero, one or two result transactions; last marks
// the final result of its input transaction.
// Each result passes through the input register and then the result queue.
// Throughput: one input transaction per cycle while the output is taken in
// every cycle; the four-entry result queue absorbs the extra result of an
// item with two results until it fills.
// Reset clears the pending sequence and empties the result queue. When the
// receiver stalls, results collect in the queue and data_ready drops once
// fewer than two entries are free while the input register holds an item.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_ready,
	input  logic [7:0]  data_byte,
	input  logic        flush,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [31:0] code_point,
	output logic        last
);
	import u8d_pkg::*;

	push_t push;
	logic  space_ok;

	// Byte decode and sequence state.
	u8d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.flush      (flush),
		.space_ok   (space_ok),
		.push       (push)
	);

	// Result queue.
	u8d_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.space_ok     (space_ok),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.code_point   (code_point),
		.last         (last)
	);

endmodule

[verif/tb_utf8_stream_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder
// Self-checking bench for the UTF-8 stream decoder. A clocked driver feeds
// bytes and flush markers from a queue of pending items, and a scoreboard
// decoder predicts the code points for every accepted input transaction. A
// clocked monitor compares each accepted result with the oldest prediction.
// Directed items cover the corner cases, and then mostly well-formed random
// sequences mixed with broken sequences and noise follow. Both sides idle
// at random, the receiver holds off once for a long stretch, and the sender
// waits twice for all predicted results to drain.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder;

	import u8d_pkg::*;

	// One pending input transaction with the idle time that follows it.
	typedef struct {
		logic [7:0] data;
		logic       fl;
		int         gap;
		bit         drain;
	} byte_item_t;

	localparam int HOLD_AT     = 400;
	localparam int HOLD_CYCLES = 300;
	localparam int N_ITEMS     = 1550;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        data_valid   = 1'b0;
	logic        data_ready;
	logic [7:0]  data_byte    = 8'h00;
	logic        flush        = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [31:0] code_point;
	logic        last;

	byte_item_t  pending[$];
	result_t     expected_points[$];
	int          n_items_total = 0;
	int          n_accepted    = 0;
	int          n_errors      = 0;
	bit          no_idle       = 1'b0;
	bit          drain_next    = 1'b0;

	// Scoreboard copy of the decoder state.
	bit          dec_open = 1'b0;
	logic [31:0] dec_acc  = 32'd0;

	// Driver and monitor working variables.
	byte_item_t  next_item;
	bit          holding;
	int          gap_left = 0;
	result_t     oldest;
	int          rx_stall_left = 0;
	int          rx_mode_left  = 0;
	bit          rx_free       = 1'b0;
	int          rx_hold_left  = 0;
	bit          rx_hold_done  = 1'b0;

	utf8_stream_decoder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_valid   (data_valid),
		.data_ready   (data_ready),
		.data_byte    (data_byte),
		.flush        (flush),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.code_point   (code_point),
		.last         (last)
	);

	always #5 clk = ~clk;

	// Idle length: mostly none or short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		else if (r < 88) return $urandom_range(1, 3);
		else if (r < 97) return $urandom_range(4, 12);
		else return $urandom_range(20, 60);
	endfunction

	// Random continuation byte.
	function automatic logic [7:0] cont_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 63));
		return CONT_TAG | b;
	endfunction

	// Starting accumulator value for a lead byte.
	function automatic logic [31:0] lead_seed(input logic [7:0] b);
		if (b < 8'hE0) return {27'd0, b[4:0]};
		else if (b < 8'hF0) return {28'd0, b[3:0]};
		else if (b < 8'hF8) return {29'd0, b[2:0]};
		else if (b < 8'hFC) return {30'd0, b[1:0]};
		else if (b < 8'hFE) return {31'd0, b[0]};
		else return 32'd0;
	endfunction

	// Overlong values, surrogates and the two noncharacters become U+FFFD.
	function automatic logic [31:0] screen_value(input logic [31:0] v);
		if (v < ASCII_LIMIT || v[31:11] == SURR_BASE[31:11] ||
				v[31:1] == NONCHAR_BASE[31:1]) return REPLACEMENT;
		return v;
	endfunction

	// Predict the code points caused by one accepted input transaction.
	task automatic decode_item(input logic [7:0] b, input logic f);
		result_t r;
		if (f) begin
			if (dec_open) begin
				r.code_point = screen_value(dec_acc);
				r.last = 1'b1;
				expected_points.push_back(r);
			end
			dec_open = 1'b0;
			dec_acc = 32'd0;
		end else if (dec_open && (b & CONT_MASK) == CONT_TAG) begin
			dec_acc = {dec_acc[25:0], b[5:0]};
		end else begin
			if (dec_open) begin
				r.code_point = screen_value(dec_acc);
				r.last = (b >= LEAD_BASE);
				expected_points.push_back(r);
				dec_open = 1'b0;
				dec_acc = 32'd0;
			end
			if (b >= LEAD_BASE) begin
				dec_open = 1'b1;
				dec_acc = lead_seed(b);
			end else begin
				r.code_point = {24'd0, b};
				r.last = 1'b1;
				expected_points.push_back(r);
			end
		end
	endtask

	task automatic push_item(input logic [7:0] b, input logic f);
		byte_item_t it;
		it.data = b;
		it.fl = f;
		it.gap = no_idle ? 0 : idle_len();
		it.drain = drain_next;
		drain_next = 1'b0;
		pending.push_back(it);
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(b, 1'b0);
	endtask

	// The byte that rides along with a flush is random; the block ignores it.
	task automatic push_flush();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		push_item(b, 1'b1);
	endtask

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 40) $display("%0t ERROR %s", $time, msg);
	endtask

	task automatic build_stimulus();
		int kind;
		int len;
		int k;
		bit drained_mid;
		logic [7:0] lead;
		drained_mid = 1'b0;

		// Directed: byte extremes, stray continuations, empty flush.
		push_byte(8'h00);
		push_byte(8'h7F);
		push_byte(8'h80);
		push_byte(8'hBF);
		push_flush();
		// A plain byte closes a sequence and then comes out as itself.
		push_byte(8'hC3);
		push_byte(8'hA9);
		push_byte(8'h41);
		// Surrogate, closed by a lead byte that opens the next sequence.
		push_byte(8'hED);
		push_byte(8'hA0);
		push_byte(8'h80);
		push_byte(8'hC2);
		push_byte(8'h80);
		// Noncharacter U+FFFF, closed by the highest lead byte.
		push_byte(8'hEF);
		push_byte(8'hBF);
		push_byte(8'hBF);
		push_byte(8'hFF);
		// Flush closes a sequence with a zero value.
		push_flush();
		// Long sequence that wraps the accumulator, closed by a flush.
		push_byte(8'hFD);
		for (k = 0; k < 6; k++) push_byte(8'hBF);
		push_flush();

		// Random part; the first item waits for the directed results.
		drain_next = 1'b1;
		while (pending.size() < N_ITEMS) begin
			if (!drained_mid && pending.size() >= 900) begin
				drain_next = 1'b1;
				drained_mid = 1'b1;
			end
			if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				// Well-formed sequence of random length and content.
				k = $urandom_range(0, 99);
				if (k < 35) len = 1;
				else if (k < 55) len = 2;
				else if (k < 75) len = 3;
				else if (k < 90) len = 4;
				else if (k < 95) len = 5;
				else len = 6;
				case (len)
					1: lead = 8'($urandom_range(0, 127));
					2: lead = 8'($urandom_range(8'hC2, 8'hDF));
					3: lead = 8'($urandom_range(8'hE0, 8'hEF));
					4: lead = 8'($urandom_range(8'hF0, 8'hF4));
					5: lead = 8'($urandom_range(8'hF8, 8'hFB));
					default: lead = 8'($urandom_range(8'hFC, 8'hFD));
				endcase
				push_byte(lead);
				for (k = 1; k < len; k++) push_byte(cont_byte());
			end else if (kind < 62) begin
				// Sequences that decode to replaced values.
				case ($urandom_range(0, 2))
					0: begin
						push_byte(8'hED);
						push_byte(8'($urandom_range(8'hA0, 8'hBF)));
						push_byte(cont_byte());
					end
					1: begin
						push_byte(8'hEF);
						push_byte(8'hBF);
						push_byte(8'($urandom_range(8'hBE, 8'hBF)));
					end
					default: begin
						push_byte(8'($urandom_range(8'hC0, 8'hC1)));
						push_byte(cont_byte());
					end
				endcase
			end else if (kind < 80) begin
				// Broken sequence: any lead, zero to seven continuations.
				push_byte(8'($urandom_range(8'hC0, 8'hFF)));
				len = $urandom_range(0, 7);
				for (k = 0; k < len; k++) push_byte(cont_byte());
				if ($urandom_range(0, 2) == 0) push_flush();
				else push_byte(8'($urandom_range(0, 255)));
			end else if (kind < 88) begin
				push_flush();
			end else begin
				push_byte(8'($urandom_range(0, 255)));
			end
		end
		push_flush();
		n_items_total = pending.size();
	endtask

	// Driver: offers pending items, predicts each accepted transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			data_valid <= 1'b0;
			gap_left <= 0;
			dec_open = 1'b0;
			dec_acc = 32'd0;
		end else begin
			if (data_valid && data_ready) begin
				decode_item(data_byte, flush);
				n_accepted <= n_accepted + 1;
			end
			holding = data_valid && !data_ready;
			if (!holding) begin
				if (gap_left > 0 && rx_hold_left == 0) begin
					data_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending.size() > 0 &&
						!(pending[0].drain && expected_points.size() != 0)) begin
					next_item = pending.pop_front();
					data_byte <= next_item.data;
					flush <= next_item.fl;
					data_valid <= 1'b1;
					gap_left <= (rx_hold_left > 0) ? 0 : next_item.gap;
				end else begin
					data_valid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off, so the result queue fills and stalls input.
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
			rx_hold_done <= 1'b0;
		end else if (!rx_hold_done && n_accepted >= HOLD_AT) begin
			rx_hold_left <= HOLD_CYCLES;
			rx_hold_done <= 1'b1;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end
	end

	// Monitor: checks results and drives result_ready.
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rx_stall_left <= 0;
			rx_mode_left <= 0;
			rx_free <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_points.size() == 0) begin
					report_mismatch($sformatf("unexpected result code_point=%h last=%b",
						code_point, last));
				end else begin
					oldest = expected_points.pop_front();
					if (code_point !== oldest.code_point)
						report_mismatch($sformatf("code_point got %h expected %h",
							code_point, oldest.code_point));
					if (last !== oldest.last)
						report_mismatch($sformatf("last got %b expected %b for %h",
							last, oldest.last, oldest.code_point));
				end
			end

			// Alternate between stretches with and without stalls.
			if (rx_mode_left == 0) begin
				rx_mode_left <= $urandom_range(50, 300);
				rx_free <= ($urandom_range(0, 3) == 0);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end

			if (rx_hold_left > 0) begin
				result_ready <= 1'b0;
			end else if (rx_stall_left > 0) begin
				result_ready <= 1'b0;
				rx_stall_left <= rx_stall_left - 1;
			end else if (!rx_free && $urandom_range(0, 99) < 25) begin
				result_ready <= 1'b0;
				rx_stall_left <= idle_len();
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Reset, stimulus and end of run.
	initial begin
		arst_n = 1'b0;
		build_stimulus();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (n_accepted != n_items_total || expected_points.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0 && expected_points.size() == 0) begin
			$display("tb_utf8_stream_decoder passed");
		end else begin
			$display("tb_utf8_stream_decoder failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#10_000_000;
		$display("tb_utf8_stream_decoder failed");
		$finish;
	end

endmodule

[files.f]
hdl/u8d_pkg.sv
hdl/u8d_decode.sv
hdl/u8d_outq.sv
hdl/utf8_stream_decoder.sv
verif/tb_utf8_stream_decoder.sv
